@@ rtl/signed_integer_to_radix_digits_assert.svh @@
// Assertion macros used by the top-level RTL.
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

`ifndef ASSERT_OFF
`define SIRAD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SIRAD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SIRAD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SIRAD_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/sirad_pkg.sv @@
package sirad_pkg;

  localparam int CHAR_W     = 8;
  localparam int SYM_IDX_W  = 4;
  localparam int COUNT_W    = 5;
  localparam int SYM_WORD_W = 64;
  localparam int NUM_SYMBOLS = 16;
  localparam int SYMS_PER_WORD = SYM_WORD_W / CHAR_W;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd10;

  typedef enum logic [1:0] {
    CFG_SYM_LOW   = 2'd0,
    CFG_SYM_HIGH  = 2'd1,
    CFG_SYM_COUNT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] radix;
  } cfg_status_t;

  typedef struct packed {
    logic                 last_bit;
    logic [SYM_IDX_W-1:0] digit;
    logic                 more;
  } div_status_t;

endpackage

@@ rtl/sirad_cfg.sv @@
module sirad_cfg
  import sirad_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [SYM_WORD_W-1:0] cfg_data,
  input  logic [SYM_IDX_W-1:0]  sym_idx,
  output logic [CHAR_W-1:0]     sym_char,
  output cfg_status_t           status
);

  logic [SYM_WORD_W-1:0] symbols_low;
  logic [SYM_WORD_W-1:0] symbols_high;
  logic [COUNT_W-1:0]    symbol_count;
  logic                  ok;
  logic [CHAR_W-1:0]     sym [NUM_SYMBOLS];
  logic                  bad;

  always_comb begin
    for (int k = 0; k < NUM_SYMBOLS; k++) begin
      if (k < SYMS_PER_WORD) begin
        sym[k] = symbols_low[k*CHAR_W +: CHAR_W];
      end else begin
        sym[k] = symbols_high[(k-SYMS_PER_WORD)*CHAR_W +: CHAR_W];
      end
    end
  end

  always_comb begin
    bad = (symbol_count < COUNT_W'(2)) || (symbol_count > COUNT_W'(MAX_SYMBOLS));
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (COUNT_W'(i) < symbol_count) begin
        if (sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
          if (COUNT_W'(j) < symbol_count && sym[i] == sym[j]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= '0;
      symbols_high <= '0;
      symbol_count <= COUNT_RESET;
      ok           <= 1'b0;
    end else begin
      ok <= !bad;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYM_LOW:   symbols_low  <= cfg_data;
          CFG_SYM_HIGH:  symbols_high <= cfg_data;
          CFG_SYM_COUNT: symbol_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign sym_char     = sym[sym_idx];
  assign status.ok    = ok;
  assign status.radix = symbol_count;

endmodule

@@ rtl/sirad_div.sv @@
module sirad_div
  import sirad_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         run,
  input  logic [COUNT_W-1:0]           radix,
  output div_status_t                  status
);

  localparam int BIT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] mag;
  logic [SYM_IDX_W-1:0]  rem;
  logic [BIT_W-1:0]      bitcnt;
  logic                  qnz;

  logic [SYM_IDX_W:0]    trial;
  logic                  qbit;
  logic [SYM_IDX_W:0]    rem_next;

  assign trial    = {rem, mag[VALUE_BITS-1]};
  assign qbit     = (trial >= radix);
  assign rem_next = qbit ? (trial - radix) : trial;

  assign status.last_bit = (bitcnt == BIT_W'(VALUE_BITS - 1));
  assign status.digit    = rem_next[SYM_IDX_W-1:0];
  assign status.more     = qnz | qbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem    <= '0;
      bitcnt <= '0;
      qnz    <= 1'b0;
    end else if (load) begin
      mag    <= value[VALUE_BITS-1] ? ($unsigned(~value) + VALUE_BITS'(1)) : $unsigned(value);
      rem    <= '0;
      bitcnt <= '0;
      qnz    <= 1'b0;
    end else if (run) begin
      mag <= {mag[VALUE_BITS-2:0], qbit};
      if (status.last_bit) begin
        rem    <= '0;
        bitcnt <= '0;
        qnz    <= 1'b0;
      end else begin
        rem    <= rem_next[SYM_IDX_W-1:0];
        bitcnt <= bitcnt + BIT_W'(1);
        qnz    <= status.more;
      end
    end
  end

endmodule

@@ rtl/signed_integer_to_radix_digits.sv @@
// Flow: a taken word passes ST_START, then the bit-serial divider (one quotient bit per
//   cycle) in ST_DIV, then a minus sign for a negative value and the digits, most significant
//   first, with one stack read per digit; an invalid alphabet drops the word in ST_START.
//   A new word is taken only in ST_IDLE, once the last character of the previous one is loaded.
// Reset: synchronous, clears control, symbol registers to 0, symbol count to 10;
//   the digit stack is not cleared.
`include "signed_integer_to_radix_digits_assert.svh"

module signed_integer_to_radix_digits
  import sirad_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [SYM_WORD_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [CHAR_W-1:0]            character,
  output logic                         last
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int IDX_W = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_SIGN,
    ST_RD,
    ST_PUT
  } state_t;

  state_t               state;
  logic                 neg;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_dec;
  logic [SYM_IDX_W-1:0] rd_digit;
  logic [SYM_IDX_W-1:0] stack [VALUE_BITS];
  logic                 out_free;
  logic                 out_load;
  logic [CHAR_W-1:0]    sym_char;
  cfg_status_t          cfg_st;
  div_status_t          div_st;

  sirad_cfg #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sym_idx  (rd_digit),
    .sym_char (sym_char),
    .status   (cfg_st)
  );

  sirad_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .load  (in_valid && in_ready),
    .value (value),
    .run   (state == ST_DIV),
    .radix (cfg_st.radix),
    .status(div_st)
  );

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && ((state == ST_SIGN && neg) || state == ST_PUT);
  assign cnt_dec  = cnt - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_st.last_bit) begin
      stack[cnt[IDX_W-1:0]] <= div_st.digit;
    end
    if (state == ST_RD) begin
      rd_digit <= stack[cnt_dec[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      neg       <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            neg   <= value[VALUE_BITS-1];
            state <= ST_START;
          end
        end
        ST_START: begin
          cnt   <= '0;
          state <= cfg_st.ok ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (div_st.last_bit) begin
            cnt <= cnt + CNT_W'(1);
            if (!div_st.more) begin
              state <= ST_SIGN;
            end
          end
        end
        ST_SIGN: begin
          if (!neg) begin
            state <= ST_RD;
          end else if (out_free) begin
            out_valid <= 1'b1;
            character <= CHAR_MINUS;
            last      <= 1'b0;
            state     <= ST_RD;
          end
        end
        ST_RD: begin
          cnt   <= cnt_dec;
          state <= ST_PUT;
        end
        ST_PUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            character <= sym_char;
            last      <= (cnt == '0);
            state     <= (cnt == '0) ? ST_IDLE : ST_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SIRAD_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CNT_W'(VALUE_BITS),
    "digit count overflow")
  `SIRAD_ASSERT_NXT(a_accept_start, clk, rst, in_valid && in_ready, state == ST_START,
    "accept did not start")
  `SIRAD_ASSERT_IMP(a_rd_nonempty, clk, rst, state == ST_RD, cnt != '0,
    "read of empty digit stack")
  `SIRAD_ASSERT_NXT(a_last_idle, clk, rst, state == ST_PUT && out_free && cnt == '0,
    state == ST_IDLE && out_valid && last, "final character not marked")

endmodule
